// ----- rtl/pic_pkg.sv -----
// Shared types and constants for the programmable interval clock.
// Used by pic_core and programmable_interval_clock; no dependencies.
`default_nettype none

package pic_pkg;

    localparam int unsigned WORD_W  = 16;
    localparam int unsigned PRESC_W = 15;
    localparam int unsigned RATE_W  = 3;
    localparam int unsigned MODE_W  = 2;

    // Item kinds carried in the input tuser.
    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_WRITE = 2'd2
    } pic_cmd_t;

    // Register select.
    localparam logic SEL_CSR    = 1'b0;
    localparam logic SEL_PRESET = 1'b1;

    // Overflow action in the MODE field; other codes free-run.
    localparam logic [MODE_W-1:0] MODE_STOP   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RELOAD = 2'd1;

    // Rate codes.
    localparam logic [RATE_W-1:0] RATE_1US     = 3'd1;
    localparam logic [RATE_W-1:0] RATE_10US    = 3'd2;
    localparam logic [RATE_W-1:0] RATE_100US   = 3'd3;
    localparam logic [RATE_W-1:0] RATE_1000US  = 3'd4;
    localparam logic [RATE_W-1:0] RATE_10000US = 3'd5;
    localparam logic [RATE_W-1:0] RATE_LINE    = 3'd7;

    // CSR bit positions.
    localparam int unsigned CSR_GO_BIT    = 0;
    localparam int unsigned CSR_MODE_LSB  = 1;
    localparam int unsigned CSR_RATE_LSB  = 3;
    localparam int unsigned CSR_INTOV_BIT = 6;
    localparam int unsigned CSR_OVFLO_BIT = 7;
    localparam int unsigned CSR_MAINT_BIT = 8;
    localparam int unsigned CSR_FOR_BIT   = 13;

    // Software-writable control bits, write-one-to-clear flags, all stored bits.
    localparam logic [WORD_W-1:0] CSR_WRMASK = 16'hD07F;
    localparam logic [WORD_W-1:0] CSR_W1C    = 16'h2080;
    localparam logic [WORD_W-1:0] CSR_STORED = CSR_WRMASK | CSR_W1C;

    typedef struct packed {
        pic_cmd_t          cmd;
        logic              reg_sel;
        logic [WORD_W-1:0] write_data;
    } pic_item_t;

    typedef struct packed {
        logic [WORD_W-1:0] read_data;
        logic              irq;
    } pic_result_t;

    // Last prescaler value of a period (period minus one).
    function automatic logic [PRESC_W-1:0] period_last(input logic [RATE_W-1:0] rate);
        logic [PRESC_W-1:0] last;
        case (rate)
            RATE_1US:     last = 15'd0;
            RATE_10US:    last = 15'd9;
            RATE_100US:   last = 15'd99;
            RATE_1000US:  last = 15'd999;
            RATE_10000US: last = 15'd9999;
            RATE_LINE:    last = 15'd16666;
            default:      last = '0;
        endcase
        return last;
    endfunction

    // Rate codes that count at all.
    function automatic logic rate_runs(input logic [RATE_W-1:0] rate);
        logic runs;
        case (rate)
            RATE_1US, RATE_10US, RATE_100US,
            RATE_1000US, RATE_10000US, RATE_LINE: runs = 1'b1;
            default:                              runs = 1'b0;
        endcase
        return runs;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/pic_core.sv -----
// Clock state (CSR, preset, counter, prescaler, interrupt) and its update logic.
// Depends on pic_pkg.
`default_nettype none

module pic_core (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               fire,
    input  wire pic_pkg::pic_item_t item,
    output pic_pkg::pic_result_t    result
);

    logic [pic_pkg::WORD_W-1:0]  status_reg, status_next;
    logic [pic_pkg::WORD_W-1:0]  preset_reg, preset_next;
    logic [pic_pkg::WORD_W-1:0]  count_reg, count_next;
    logic [pic_pkg::PRESC_W-1:0] prescale_reg, prescale_next;
    logic                        irq_reg, irq_next;
    logic [pic_pkg::WORD_W-1:0]  read_value;

    always_comb begin
        logic [pic_pkg::WORD_W-1:0] cnt_inc;
        logic [pic_pkg::RATE_W-1:0] rate;
        logic [pic_pkg::MODE_W-1:0] mode;

        status_next   = status_reg;
        preset_next   = preset_reg;
        count_next    = count_reg;
        prescale_next = prescale_reg;
        irq_next      = irq_reg;
        read_value    = '0;

        cnt_inc = count_reg + pic_pkg::WORD_W'(1);
        rate    = status_reg[pic_pkg::CSR_RATE_LSB +: pic_pkg::RATE_W];
        mode    = status_reg[pic_pkg::CSR_MODE_LSB +: pic_pkg::MODE_W];

        case (item.cmd)
            pic_pkg::CMD_TICK: begin
                if (status_reg[pic_pkg::CSR_GO_BIT] && pic_pkg::rate_runs(rate)) begin
                    if (prescale_reg >= pic_pkg::period_last(rate)) begin
                        prescale_next = '0;
                        count_next    = cnt_inc;
                        if (cnt_inc == '0) begin
                            // overflow: flag, overrun, mode action, interrupt
                            if (status_reg[pic_pkg::CSR_OVFLO_BIT]) begin
                                status_next[pic_pkg::CSR_FOR_BIT] = 1'b1;
                            end
                            status_next[pic_pkg::CSR_OVFLO_BIT] = 1'b1;
                            if (mode == pic_pkg::MODE_STOP) begin
                                status_next[pic_pkg::CSR_GO_BIT] = 1'b0;
                            end else if (mode == pic_pkg::MODE_RELOAD) begin
                                count_next = preset_reg;
                            end
                            if (status_reg[pic_pkg::CSR_INTOV_BIT]) begin
                                irq_next = 1'b1;
                            end
                        end
                    end else begin
                        prescale_next = prescale_reg + pic_pkg::PRESC_W'(1);
                    end
                end
            end
            pic_pkg::CMD_READ: begin
                if (item.reg_sel == pic_pkg::SEL_PRESET) begin
                    read_value = preset_reg;
                end else begin
                    read_value  = status_reg;
                    status_next = status_reg & ~pic_pkg::CSR_W1C;
                    irq_next    = 1'b0;
                end
            end
            pic_pkg::CMD_WRITE: begin
                if (item.reg_sel == pic_pkg::SEL_PRESET) begin
                    preset_next = item.write_data;
                    if (status_reg[pic_pkg::CSR_GO_BIT] && mode == pic_pkg::MODE_STOP) begin
                        count_next = item.write_data;
                    end
                end else begin
                    status_next = status_reg & ~(item.write_data & pic_pkg::CSR_W1C);
                    status_next = (status_next & ~pic_pkg::CSR_WRMASK)
                                | (item.write_data & pic_pkg::CSR_WRMASK);
                    if (item.write_data[pic_pkg::CSR_MAINT_BIT]) begin
                        count_next = cnt_inc;
                        if (cnt_inc == '0) begin
                            status_next[pic_pkg::CSR_OVFLO_BIT] = 1'b1;
                            if (status_next[pic_pkg::CSR_INTOV_BIT]) begin
                                irq_next = 1'b1;
                            end
                        end
                    end
                    prescale_next = '0;
                    if (!status_next[pic_pkg::CSR_OVFLO_BIT]) begin
                        irq_next = 1'b0;
                    end
                end
            end
            default: begin
                // unused code: no state change
            end
        endcase
    end

    assign result.read_data = read_value;
    assign result.irq       = irq_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg   <= '0;
            preset_reg   <= '0;
            count_reg    <= '0;
            prescale_reg <= '0;
            irq_reg      <= 1'b0;
        end else if (fire) begin
            status_reg   <= status_next;
            preset_reg   <= preset_next;
            count_reg    <= count_next;
            prescale_reg <= prescale_next;
            irq_reg      <= irq_next;
        end
    end

    a_csr_unused_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (status_reg & ~pic_pkg::CSR_STORED) == '0)
        else $error("CSR holds a bit outside the stored set");

    a_prescale_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        prescale_reg <= 15'd16666)
        else $error("prescaler beyond longest period");

    a_read_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item.cmd == pic_pkg::CMD_READ && item.reg_sel == pic_pkg::SEL_CSR
        |=> !irq_reg && (status_reg & pic_pkg::CSR_W1C) == '0)
        else $error("CSR read did not clear flags and interrupt");

endmodule

`default_nettype wire

// ----- rtl/programmable_interval_clock.sv -----
// Top level of the programmable interval clock: input register, state core,
// result register. Depends on pic_pkg and pic_core.
// Each item passes through the input register and then the result register before its
// result can be transferred.
// Throughput: one item per cycle while the result side accepts; back-pressure on the
// result side stalls the input register, which takes a new item only while it is empty.
// Reset (aresetn low, synchronous) clears CSR, preset, counter, prescaler,
// interrupt and both stage valid flags.
`default_nettype none

module programmable_interval_clock (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [15:0] write_data
    input  wire logic [2:0]  s_axis_tuser,   // [1:0] cmd, [2] reg_sel
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [15:0] read_data
    output logic             m_axis_tuser    // [0] irq
);

    logic                 in_valid_reg;
    pic_pkg::pic_item_t   in_item_reg;
    logic                 out_valid_reg;
    pic_pkg::pic_result_t out_result_reg;
    pic_pkg::pic_result_t core_result;
    logic                 advance;

    // Move the held item into the result register when that register is free
    // or being drained this cycle; state is committed at the same edge.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    // Take a new item when the input register is empty or moves on this cycle.
    assign s_axis_tready = !in_valid_reg || advance;

    pic_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (advance),
        .item    (in_item_reg),
        .result  (core_result)
    );

    // Input register: hold the item until the core consumes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_item_reg.cmd        <= pic_pkg::pic_cmd_t'(s_axis_tuser[1:0]);
            in_item_reg.reg_sel    <= s_axis_tuser[2];
            in_item_reg.write_data <= s_axis_tdata;
        end
    end

    // Result register: load on advance, drop after the transfer completes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_result_reg <= core_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_result_reg.read_data;
    assign m_axis_tuser  = out_result_reg.irq;

    a_advance_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("advanced item missing from result register");

    a_stall_holds_input: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_item_reg))
        else $error("held item lost while result side stalled");

    a_idle_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_axis_tready)
        else $error("empty input register refused a transfer");

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// Self-checking testbench for programmable_interval_clock: drives bus reads, writes and
// microsecond ticks, predicts every result in a local copy of the clock state and checks it.
// Depends on pic_pkg and the programmable_interval_clock RTL only.
`timescale 1ns / 1ps

module tb;

    localparam logic [1:0]                 CMD_NONE   = 2'd3; // unused code, block ignores it
    localparam logic [pic_pkg::RATE_W-1:0] RATE_OFF_A = 3'd0; // rate codes that stop counting
    localparam logic [pic_pkg::RATE_W-1:0] RATE_OFF_B = 3'd6;
    localparam logic [pic_pkg::WORD_W-1:0] CSR_STEP   = 16'd1 << pic_pkg::CSR_MAINT_BIT;
    localparam logic [pic_pkg::WORD_W-1:0] SPARE_BITS = 16'hD000; // plain storage bits 12, 14, 15
    localparam int unsigned                PHASE_OPS  = 367;
    localparam int unsigned                DRAIN_CYC  = 8;
    localparam int unsigned                LIMIT_CYC  = 200000;

    typedef struct packed {
        logic [1:0]                 cmd;
        logic                       sel;
        logic [pic_pkg::WORD_W-1:0] data;
    } bus_op_t;

    logic              aclk;
    logic              aresetn       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [15:0]       s_axis_tdata  = '0;    // [15:0] write_data
    logic [2:0]        s_axis_tuser  = '0;    // [1:0] cmd, [2] reg_sel
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [15:0]       m_axis_tdata;          // [15:0] read_data
    logic              m_axis_tuser;          // [0] irq

    bus_op_t              op_q[$];            // transfers waiting for the driver
    pic_pkg::pic_result_t resp_due[$];        // predicted results, oldest first
    logic                 in_fire    = 1'b0;  // input transfer at the last rising edge
    int unsigned          send_idle  = 21;
    int unsigned          recv_idle  = 84;
    int unsigned          n_real     = 0;     // non-ignored items queued so far
    int unsigned          fail_count = 0;
    int unsigned          cycle_cnt  = 0;

    // Local copy of the clock state
    logic [pic_pkg::WORD_W-1:0]  clk_csr    = '0;
    logic [pic_pkg::WORD_W-1:0]  clk_preset = '0;
    logic [pic_pkg::WORD_W-1:0]  clk_count  = '0;
    logic [pic_pkg::PRESC_W-1:0] clk_presc  = '0;
    logic                        clk_irq    = 1'b0;

    programmable_interval_clock DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Microseconds per counter step; zero for the codes that stop counting.
    function automatic int unsigned rate_period(input logic [pic_pkg::RATE_W-1:0] rate);
        case (rate)
            pic_pkg::RATE_1US:     return 1;
            pic_pkg::RATE_10US:    return 10;
            pic_pkg::RATE_100US:   return 100;
            pic_pkg::RATE_1000US:  return 1000;
            pic_pkg::RATE_10000US: return 10000;
            pic_pkg::RATE_LINE:    return 16667;
            default:               return 0;
        endcase
    endfunction

    // Apply one transfer to the local clock state and return the result it produces.
    function automatic pic_pkg::pic_result_t clock_response(input bus_op_t op);
        pic_pkg::pic_result_t       res;
        logic [pic_pkg::WORD_W-1:0] rd;
        logic [pic_pkg::MODE_W-1:0] mode;
        int unsigned                per;
        rd = '0;
        case (op.cmd)
            pic_pkg::CMD_TICK: begin
                per = rate_period(clk_csr[pic_pkg::CSR_RATE_LSB +: pic_pkg::RATE_W]);
                if (clk_csr[pic_pkg::CSR_GO_BIT] && per != 0) begin
                    if (clk_presc + 1 >= per) begin
                        clk_presc = '0;
                        clk_count = clk_count + 1'b1;
                        if (clk_count == '0) begin
                            // overflow: a second one before the flag is read is an overrun
                            if (clk_csr[pic_pkg::CSR_OVFLO_BIT])
                                clk_csr[pic_pkg::CSR_FOR_BIT] = 1'b1;
                            clk_csr[pic_pkg::CSR_OVFLO_BIT] = 1'b1;
                            mode = clk_csr[pic_pkg::CSR_MODE_LSB +: pic_pkg::MODE_W];
                            if (mode == pic_pkg::MODE_STOP)
                                clk_csr[pic_pkg::CSR_GO_BIT] = 1'b0;
                            else if (mode == pic_pkg::MODE_RELOAD)
                                clk_count = clk_preset;
                            if (clk_csr[pic_pkg::CSR_INTOV_BIT])
                                clk_irq = 1'b1;
                        end
                    end else begin
                        clk_presc = clk_presc + 1'b1;
                    end
                end
            end
            pic_pkg::CMD_READ: begin
                if (op.sel == pic_pkg::SEL_PRESET) begin
                    rd = clk_preset;
                end else begin
                    rd = clk_csr;
                    clk_csr = clk_csr & ~pic_pkg::CSR_W1C;
                    clk_irq = 1'b0;
                end
            end
            pic_pkg::CMD_WRITE: begin
                if (op.sel == pic_pkg::SEL_PRESET) begin
                    clk_preset = op.data;
                    if (clk_csr[pic_pkg::CSR_GO_BIT]
                        && clk_csr[pic_pkg::CSR_MODE_LSB +: pic_pkg::MODE_W] == pic_pkg::MODE_STOP)
                        clk_count = clk_preset;
                end else begin
                    clk_csr = clk_csr & ~(op.data & pic_pkg::CSR_W1C);
                    clk_csr = (clk_csr & ~pic_pkg::CSR_WRMASK) | (op.data & pic_pkg::CSR_WRMASK);
                    // maintenance step: flag only, no overrun and no mode action
                    if (op.data[pic_pkg::CSR_MAINT_BIT]) begin
                        clk_count = clk_count + 1'b1;
                        if (clk_count == '0) begin
                            clk_csr[pic_pkg::CSR_OVFLO_BIT] = 1'b1;
                            if (clk_csr[pic_pkg::CSR_INTOV_BIT])
                                clk_irq = 1'b1;
                        end
                    end
                    clk_presc = '0;
                    if (!clk_csr[pic_pkg::CSR_OVFLO_BIT])
                        clk_irq = 1'b0;
                end
            end
            default: ;
        endcase
        res.read_data = rd;
        res.irq       = clk_irq;
        return res;
    endfunction

    // Driver: present the next queued transfer at the falling edge.
    always @(negedge aclk) begin : drv
        bus_op_t op;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_fire) begin
            if (op_q.size() != 0 && $urandom_range(99) >= send_idle) begin
                op = op_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= op.data;
                s_axis_tuser  <= {op.sel, op.cmd};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        m_axis_tready <= aresetn && ($urandom_range(99) >= recv_idle);
    end

    // Monitor: check results against the oldest prediction, then predict new transfers.
    always @(posedge aclk) begin : mon
        pic_pkg::pic_result_t want;
        bus_op_t              op;
        cycle_cnt = cycle_cnt + 1;
        if (!aresetn) begin
            in_fire <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (resp_due.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result: read_data %h irq %b",
                                 m_axis_tdata, m_axis_tuser);
                    fail_count = fail_count + 1;
                end else begin
                    want = resp_due.pop_front();
                    if (m_axis_tdata !== want.read_data || m_axis_tuser !== want.irq) begin
                        if (fail_count < 10)
                            $display("mismatch: read_data exp %h got %h, irq exp %b got %b",
                                     want.read_data, m_axis_tdata, want.irq, m_axis_tuser);
                        fail_count = fail_count + 1;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                op.cmd  = s_axis_tuser[1:0];
                op.sel  = s_axis_tuser[2];
                op.data = s_axis_tdata;
                resp_due.push_back(clock_response(op));
            end
            in_fire <= s_axis_tvalid && s_axis_tready;
        end
        if (cycle_cnt >= LIMIT_CYC) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    task automatic put(input logic [1:0] c, input logic s,
                       input logic [pic_pkg::WORD_W-1:0] d);
        bus_op_t op;
        op.cmd  = c;
        op.sel  = s;
        op.data = d;
        op_q.push_back(op);
        if (c != CMD_NONE)
            n_real = n_real + 1;
    endtask

    function automatic logic [pic_pkg::WORD_W-1:0] csr_word(input logic go,
                                                   input logic [pic_pkg::MODE_W-1:0] mode,
                                                   input logic [pic_pkg::RATE_W-1:0] rate,
                                                   input logic intov);
        logic [pic_pkg::WORD_W-1:0] w;
        w = '0;
        w[pic_pkg::CSR_GO_BIT]                     = go;
        w[pic_pkg::CSR_MODE_LSB +: pic_pkg::MODE_W] = mode;
        w[pic_pkg::CSR_RATE_LSB +: pic_pkg::RATE_W] = rate;
        w[pic_pkg::CSR_INTOV_BIT]                  = intov;
        return w;
    endfunction

    // Mostly fast rates so overflows happen within a few hundred ticks.
    function automatic logic [pic_pkg::RATE_W-1:0] pick_rate();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 48) return pic_pkg::RATE_1US;
        if (r < 78) return pic_pkg::RATE_10US;
        if (r < 82) return pic_pkg::RATE_100US;
        if (r < 88) return ($urandom_range(1) != 0) ? RATE_OFF_A : RATE_OFF_B;
        case ($urandom_range(2))
            0:       return pic_pkg::RATE_1000US;
            1:       return pic_pkg::RATE_10000US;
            default: return pic_pkg::RATE_LINE;
        endcase
    endfunction

    // Load the counter near the top, pick a mode, then tick toward one or more overflows
    // with reads and writes mixed in.
    task automatic overflow_run();
        logic [pic_pkg::RATE_W-1:0] rate;
        logic                       intov;
        int unsigned                per;
        int unsigned                steps;
        int unsigned                r;
        rate  = pick_rate();
        intov = 1'($urandom_range(1));
        per   = rate_period(rate);
        put(pic_pkg::CMD_WRITE, pic_pkg::SEL_CSR,
            csr_word(1'b1, pic_pkg::MODE_STOP, rate, intov)
            | (16'($urandom) & SPARE_BITS)
            | (($urandom_range(3) == 0) ? pic_pkg::CSR_W1C : '0));
        put(pic_pkg::CMD_WRITE, pic_pkg::SEL_PRESET, 16'(16'hFFFF - $urandom_range(3)));
        if ($urandom_range(1) != 0)
            put(pic_pkg::CMD_WRITE, pic_pkg::SEL_CSR,
                csr_word(1'b1, 2'($urandom_range(3)), rate, intov)
                | (16'($urandom) & SPARE_BITS));
        steps = (per == 0) ? $urandom_range(2, 6)
                           : per * $urandom_range(1, 4) + $urandom_range(0, 3);
        if (steps > 250)
            steps = (per <= 100) ? per + $urandom_range(0, 20) : $urandom_range(10, 40);
        for (int i = 0; i < steps; i++) begin
            r = $urandom_range(99);
            if (r < 8)
                put(pic_pkg::CMD_READ, 1'($urandom_range(1)), 16'($urandom));
            else if (r < 11)
                put(pic_pkg::CMD_WRITE, pic_pkg::SEL_PRESET,
                    ($urandom_range(1) != 0) ? 16'(16'hFFFF - $urandom_range(7))
                                             : 16'($urandom));
            else if (r < 12)
                put(pic_pkg::CMD_WRITE, pic_pkg::SEL_CSR,
                    csr_word(1'b1, 2'($urandom_range(3)), rate, intov)
                    | CSR_STEP | (16'($urandom) & pic_pkg::CSR_W1C));
            else
                put(pic_pkg::CMD_TICK, 1'($urandom_range(1)), 16'($urandom));
        end
        if ($urandom_range(1) != 0)
            put(pic_pkg::CMD_READ, pic_pkg::SEL_CSR, 16'($urandom));
    endtask

    // Reach overflow through maintenance steps alone.
    task automatic step_run();
        int unsigned k;
        logic        intov;
        k     = $urandom_range(3);
        intov = 1'($urandom_range(1));
        put(pic_pkg::CMD_WRITE, pic_pkg::SEL_CSR,
            csr_word(1'b1, pic_pkg::MODE_STOP, RATE_OFF_A, intov));
        put(pic_pkg::CMD_WRITE, pic_pkg::SEL_PRESET, 16'(16'hFFFF - k));
        for (int i = 0; i <= k; i++)
            put(pic_pkg::CMD_WRITE, pic_pkg::SEL_CSR,
                csr_word(1'($urandom_range(1)), 2'($urandom_range(3)),
                         3'($urandom_range(7)), intov) | CSR_STEP);
        if ($urandom_range(1) != 0)
            put(pic_pkg::CMD_READ, pic_pkg::SEL_CSR, 16'($urandom));
    endtask

    task automatic noise_run();
        int unsigned n;
        n = $urandom_range(4, 10);
        for (int i = 0; i < n; i++)
            put(2'($urandom_range(3)), 1'($urandom_range(1)), 16'($urandom));
    endtask

    task automatic random_part(input int unsigned count);
        int unsigned goal;
        int unsigned r;
        goal = n_real + count;
        while (n_real < goal) begin
            r = $urandom_range(99);
            if (r < 65)
                overflow_run();
            else if (r < 80)
                step_run();
            else
                noise_run();
        end
    endtask

    // Hold until every queued transfer is accepted and every result has come back.
    task automatic wait_drained();
        while (op_q.size() != 0 || s_axis_tvalid || resp_due.size() != 0)
            @(negedge aclk);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: reset values, stop-mode overflow, maintenance step, overrun in reload mode,
        // all-ones write, the unused command and the stopping rate codes.
        put(pic_pkg::CMD_READ,  pic_pkg::SEL_CSR,    16'h0000);
        put(pic_pkg::CMD_READ,  pic_pkg::SEL_PRESET, 16'hFFFF);
        put(pic_pkg::CMD_WRITE, pic_pkg::SEL_PRESET, 16'hFFFF); // GO clear: counter not loaded
        put(pic_pkg::CMD_WRITE, pic_pkg::SEL_CSR,
            csr_word(1'b1, pic_pkg::MODE_STOP, pic_pkg::RATE_1US, 1'b1));
        put(pic_pkg::CMD_WRITE, pic_pkg::SEL_PRESET, 16'hFFFE); // loads the counter in stop mode
        put(pic_pkg::CMD_TICK,  pic_pkg::SEL_CSR,    16'h0000);
        put(pic_pkg::CMD_TICK,  pic_pkg::SEL_PRESET, 16'hFFFF); // overflow drops GO
        put(pic_pkg::CMD_TICK,  pic_pkg::SEL_CSR,    16'h0000);
        put(pic_pkg::CMD_READ,  pic_pkg::SEL_CSR,    16'h0000);
        put(pic_pkg::CMD_WRITE, pic_pkg::SEL_CSR,
            csr_word(1'b1, pic_pkg::MODE_STOP, pic_pkg::RATE_1US, 1'b1));
        put(pic_pkg::CMD_WRITE, pic_pkg::SEL_PRESET, 16'hFFFF);
        put(pic_pkg::CMD_WRITE, pic_pkg::SEL_CSR,
            csr_word(1'b1, pic_pkg::MODE_STOP, pic_pkg::RATE_1US, 1'b1) | CSR_STEP);
        put(pic_pkg::CMD_WRITE, pic_pkg::SEL_CSR,
            csr_word(1'b1, pic_pkg::MODE_STOP, pic_pkg::RATE_1US, 1'b0));
        put(pic_pkg::CMD_WRITE, pic_pkg::SEL_PRESET, 16'hFFFF);
        put(pic_pkg::CMD_WRITE, pic_pkg::SEL_CSR,
            csr_word(1'b1, pic_pkg::MODE_RELOAD, pic_pkg::RATE_1US, 1'b1) | pic_pkg::CSR_W1C);
        put(pic_pkg::CMD_TICK,  pic_pkg::SEL_CSR,    16'h0000);
        put(pic_pkg::CMD_TICK,  pic_pkg::SEL_CSR,    16'h0000); // second overflow: overrun
        put(pic_pkg::CMD_READ,  pic_pkg::SEL_CSR,    16'h0000);
        put(pic_pkg::CMD_WRITE, pic_pkg::SEL_CSR,    16'hFFFF);
        put(pic_pkg::CMD_READ,  pic_pkg::SEL_CSR,    16'h0000);
        put(pic_pkg::CMD_READ,  pic_pkg::SEL_PRESET, 16'h0000);
        put(CMD_NONE,           pic_pkg::SEL_PRESET, 16'hA5A5);
        put(pic_pkg::CMD_WRITE, pic_pkg::SEL_CSR,
            csr_word(1'b1, pic_pkg::MODE_STOP, RATE_OFF_A, 1'b1));
        put(pic_pkg::CMD_TICK,  pic_pkg::SEL_CSR,    16'h0000);
        put(pic_pkg::CMD_WRITE, pic_pkg::SEL_CSR,
            csr_word(1'b1, pic_pkg::MODE_STOP, RATE_OFF_B, 1'b1));
        put(pic_pkg::CMD_TICK,  pic_pkg::SEL_CSR,    16'h0000);
        put(pic_pkg::CMD_WRITE, pic_pkg::SEL_CSR,    16'h0000);

        // Random part in three idling phases; the sender drains fully between them.
        random_part(PHASE_OPS);
        wait_drained();
        send_idle <= 84;
        recv_idle <= 21;
        random_part(PHASE_OPS);
        wait_drained();
        send_idle <= 0;
        recv_idle <= 0;
        random_part(PHASE_OPS);
        wait_drained();
        repeat (DRAIN_CYC) @(negedge aclk);

        if (resp_due.size() != 0)
            fail_count = fail_count + 1;
        if (fail_count == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
